FILE: src/fcw_pkg.sv
`default_nettype none

package fcw_pkg;

  // Field widths fixed by the item and result formats
  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 6;
  localparam int CLUSTER_W = 7;
  localparam int START_W   = 6;
  localparam int NAME_W    = 64;
  localparam int POS_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  // Longest list ever reported, before the table size cuts it shorter
  localparam int MAX_LIST = 64;

  typedef logic [CMD_W-1:0]            cmd_t;
  typedef logic [SLOT_W-1:0]           slot_t;
  typedef logic signed [CLUSTER_W-1:0] cluster_t;
  typedef logic [START_W-1:0]          start_t;
  typedef logic [NAME_W-1:0]           name_t;
  typedef logic [POS_W-1:0]            pos_t;
  typedef logic [STATUS_W-1:0]         status_t;
  typedef logic [COUNT_W-1:0]          count_t;

  typedef struct packed {
    start_t start;
    name_t  name;
  } dir_entry_t;

  localparam cmd_t CMD_FAT_WR = 2'd0;
  localparam cmd_t CMD_DIR_WR = 2'd1;
  localparam cmd_t CMD_LIST   = 2'd2;
  localparam cmd_t CMD_FIND   = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_PAST_END  = 2'd2;
  localparam status_t ST_BAD       = 2'd3;

  localparam cluster_t NO_CLUSTER = -7'sd1;

endpackage

`default_nettype wire

FILE: src/fcw_if.sv
`default_nettype none

interface fcw_item_if;
  logic               valid;
  logic               ready;
  fcw_pkg::cmd_t      cmd;
  fcw_pkg::slot_t     slot;
  fcw_pkg::cluster_t  next_cluster;
  fcw_pkg::name_t     file_name;
  fcw_pkg::start_t    start_cluster;
  fcw_pkg::pos_t      position;

  modport source (
    output valid, cmd, slot, next_cluster, file_name, start_cluster, position,
    input  ready
  );
  modport sink (
    input  valid, cmd, slot, next_cluster, file_name, start_cluster, position,
    output ready
  );
endinterface

interface fcw_result_if;
  logic               valid;
  logic               ready;
  fcw_pkg::cluster_t  cluster;
  fcw_pkg::status_t   status;
  logic               last;

  modport source (
    output valid, cluster, status, last,
    input  ready
  );
  modport sink (
    input  valid, cluster, status, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/fcw_ram.sv
`default_nettype none

module fcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [AW-1:0]           raddr,
  output logic      [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/fat_chain_walker_top.sv
// FAT cluster-chain walker.
// items (sink): one command per transfer. Write FAT entry and write directory
//   entry each answer with one acknowledgement (cluster -1, status ok, last).
//   List answers with every cluster of the named file's chain, last set on the
//   final one; find answers with the cluster of the position-th block.
// results (source): one registered result per transfer, last marks the final
//   result of a command. Error results always carry last.
// cfg_we/cfg_wdata: dir_count, the number of directory slots searched; write
//   it only while no command is in flight.
// A write command passes through an acknowledgement state, which loads the
//   acknowledgement once the output register is free and then returns to idle for
//   the next command. A lookup scans the directory RAM one slot per cycle, then
//   walks the FAT RAM one link at a time through a walk state and a check state,
//   since each read address is the data of the previous read through one registered read port.
// items.ready is high only while the sequencer is idle; a finished result may
//   still sit in the output register. A stalled receiver holds the walk at the
//   next result, nothing is dropped.
// Reset clears the sequencer, the output valid flag and dir_count. Table
//   contents are not cleared and must be written before they are read.
`default_nettype none

module fat_chain_walker_top #(
  parameter int FAT_ENTRIES = 64,
  parameter int DIR_ENTRIES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  fcw_item_if.sink              items,
  fcw_result_if.source          results,
  input  wire logic             cfg_we,
  input  wire fcw_pkg::count_t  cfg_wdata
);

  localparam int FAW      = (FAT_ENTRIES > 1) ? $clog2(FAT_ENTRIES) : 1;
  localparam int DAW      = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int LIST_LIM = (FAT_ENTRIES < fcw_pkg::MAX_LIST) ? FAT_ENTRIES
                                                              : fcw_pkg::MAX_LIST;
  localparam int DIR_W    = $bits(fcw_pkg::dir_entry_t);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACK   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_LWALK = 3'd3;
  localparam logic [2:0] S_LCHK  = 3'd4;
  localparam logic [2:0] S_FWALK = 3'd5;
  localparam logic [2:0] S_FCHK  = 3'd6;

  logic [2:0]            state, state_next;
  fcw_pkg::count_t       dir_count;
  fcw_pkg::count_t       idx, idx_next;
  logic                  rd_pend, rd_pend_next;
  fcw_pkg::start_t       c, c_next;
  fcw_pkg::pos_t         k, k_next;
  fcw_pkg::cmd_t         cmd_r;
  fcw_pkg::name_t        name_r;
  fcw_pkg::pos_t         pos_r;

  logic                  out_valid;
  fcw_pkg::cluster_t     out_cluster;
  fcw_pkg::status_t      out_status;
  logic                  out_last;
  logic                  out_load;
  fcw_pkg::cluster_t     load_cluster;
  fcw_pkg::status_t      load_status;
  logic                  load_last;

  logic                  accept;
  logic                  out_free;
  fcw_pkg::count_t       n_dir;
  logic                  c_bad;
  fcw_pkg::cluster_t     c_as_cluster;

  logic                  fat_we;
  logic [FAW-1:0]        fat_waddr, fat_raddr;
  fcw_pkg::cluster_t     fat_rdata;
  logic                  dir_we;
  logic [DAW-1:0]        dir_waddr, dir_raddr;
  fcw_pkg::dir_entry_t   dir_wdata, dir_rdata;

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign out_free    = !out_valid || results.ready;

  assign results.valid   = out_valid;
  assign results.cluster = out_cluster;
  assign results.status  = out_status;
  assign results.last    = out_last;

  assign n_dir = (32'(dir_count) > DIR_ENTRIES) ? fcw_pkg::count_t'(DIR_ENTRIES)
                                                : dir_count;
  assign c_bad        = (32'(c) >= FAT_ENTRIES);
  assign c_as_cluster = fcw_pkg::cluster_t'({1'b0, c});

  // Table writes go straight from the accepted item
  assign fat_we    = accept && (items.cmd == fcw_pkg::CMD_FAT_WR) &&
                     (32'(items.slot) < FAT_ENTRIES);
  assign fat_waddr = FAW'(items.slot);
  assign fat_raddr = FAW'(c);
  assign dir_we    = accept && (items.cmd == fcw_pkg::CMD_DIR_WR) &&
                     (32'(items.slot) < DIR_ENTRIES);
  assign dir_waddr = DAW'(items.slot);
  assign dir_wdata = '{start: items.start_cluster, name: items.file_name};
  assign dir_raddr = DAW'(idx);

  fcw_ram #(
    .WIDTH (fcw_pkg::CLUSTER_W),
    .DEPTH (FAT_ENTRIES)
  ) u_fat_ram (
    .clk   (clk),
    .we    (fat_we),
    .waddr (fat_waddr),
    .wdata (items.next_cluster),
    .raddr (fat_raddr),
    .rdata (fat_rdata)
  );

  fcw_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DIR_ENTRIES)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    rd_pend_next = rd_pend;
    c_next       = c;
    k_next       = k;
    out_load     = 1'b0;
    load_cluster = fcw_pkg::NO_CLUSTER;
    load_status  = fcw_pkg::ST_OK;
    load_last    = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (items.cmd inside {fcw_pkg::CMD_FAT_WR, fcw_pkg::CMD_DIR_WR}) begin
            state_next = S_ACK;
          end else begin
            state_next   = S_SCAN;
            idx_next     = '0;
            rd_pend_next = 1'b0;
          end
        end
      end
      S_ACK: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        // rdata holds slot idx-1 when rd_pend is set
        if (rd_pend && dir_rdata.name == name_r) begin
          rd_pend_next = 1'b0;
          c_next       = dir_rdata.start;
          if (cmd_r == fcw_pkg::CMD_LIST) begin
            k_next     = '0;
            state_next = S_LWALK;
          end else begin
            k_next     = fcw_pkg::pos_t'(1);
            state_next = S_FWALK;
          end
        end else if (idx == n_dir) begin
          rd_pend_next = 1'b0;
          if (out_free) begin
            out_load    = 1'b1;
            load_status = fcw_pkg::ST_NOT_FOUND;
            state_next  = S_IDLE;
          end
        end else begin
          idx_next     = idx + 1'b1;
          rd_pend_next = 1'b1;
        end
      end
      S_LWALK: begin
        if (c_bad) begin
          if (out_free) begin
            out_load     = 1'b1;
            load_cluster = c_as_cluster;
            load_status  = fcw_pkg::ST_BAD;
            state_next   = S_IDLE;
          end
        end else begin
          state_next = S_LCHK;
        end
      end
      S_LCHK: begin
        if (out_free) begin
          out_load     = 1'b1;
          load_cluster = c_as_cluster;
          if (fat_rdata[fcw_pkg::CLUSTER_W-1]) begin
            state_next = S_IDLE;
          end else if (32'(k) == LIST_LIM - 1) begin
            load_status = fcw_pkg::ST_BAD;
            state_next  = S_IDLE;
          end else begin
            load_last  = 1'b0;
            k_next     = k + 1'b1;
            c_next     = fcw_pkg::start_t'(fat_rdata);
            state_next = S_LWALK;
          end
        end
      end
      S_FWALK: begin
        if (pos_r == '0 || (k < pos_r && (c_bad || 32'(k) >= FAT_ENTRIES))) begin
          if (out_free) begin
            out_load    = 1'b1;
            load_status = fcw_pkg::ST_BAD;
            state_next  = S_IDLE;
          end
        end else if (k < pos_r) begin
          state_next = S_FCHK;
        end else if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (c_bad) begin
            load_status = fcw_pkg::ST_BAD;
          end else begin
            load_cluster = c_as_cluster;
          end
        end
      end
      S_FCHK: begin
        if (fat_rdata[fcw_pkg::CLUSTER_W-1]) begin
          if (out_free) begin
            out_load    = 1'b1;
            load_status = fcw_pkg::ST_PAST_END;
            state_next  = S_IDLE;
          end
        end else begin
          c_next     = fcw_pkg::start_t'(fat_rdata);
          k_next     = k + 1'b1;
          state_next = S_FWALK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      dir_count <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        dir_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    c   <= c_next;
    k   <= k_next;
    if (accept) begin
      cmd_r  <= items.cmd;
      name_r <= items.file_name;
      pos_r  <= items.position;
    end
    if (out_load) begin
      out_cluster <= load_cluster;
      out_status  <= load_status;
      out_last    <= load_last;
    end
  end

  a_write_acks: assert property (@(posedge clk) disable iff (rst)
    accept && (items.cmd == fcw_pkg::CMD_FAT_WR || items.cmd == fcw_pkg::CMD_DIR_WR)
    |=> state == S_ACK)
    else $error("write command did not go to acknowledgement");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status != fcw_pkg::ST_OK |-> results.last)
    else $error("error result without last");

  a_more_only_in_list: assert property (@(posedge clk) disable iff (rst)
    out_load && !load_last |-> cmd_r == fcw_pkg::CMD_LIST && state == S_LCHK)
    else $error("non-final result outside a list walk");

  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_LCHK |-> 32'(k) < LIST_LIM)
    else $error("list walk ran past its length limit");

endmodule

`default_nettype wire

FILE: tb/fcw_result_checker.sv
module fcw_result_checker
  import fcw_pkg::*;
#(
  parameter int FAT_ENTRIES = 64,
  parameter int DIR_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  fcw_item_if         items,
  fcw_result_if       results,
  input  logic        cfg_we,
  input  count_t      cfg_wdata,
  output int unsigned outstanding,
  output int unsigned mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cluster_t cluster;
    status_t  status;
    logic     last;
  } answer_t;

  // Own copy of the block's tables and register
  cluster_t fat_links  [FAT_ENTRIES];
  name_t    dir_names  [DIR_ENTRIES];
  start_t   dir_starts [DIR_ENTRIES];
  count_t   dir_span;

  answer_t  answer_queue [$];

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 200) begin
      $display("%0t ns checker: %s", $time, msg);
    end
  endtask

  function automatic void push_answer(input cluster_t c, input status_t s, input logic l);
    answer_t a;
    a.cluster = c;
    a.status  = s;
    a.last    = l;
    answer_queue.push_back(a);
  endfunction

  // First matching slot among those in use, -1 when none
  function automatic int find_dir_slot(input name_t name);
    int n;
    int hit;
    n = (dir_span > DIR_ENTRIES) ? DIR_ENTRIES : int'(dir_span);
    hit = -1;
    for (int i = 0; i < n; i++) begin
      if (hit < 0 && dir_names[i] == name) hit = i;
    end
    return hit;
  endfunction

  task automatic predict_answers();
    int  hit;
    int  c;
    int  k;
    int  lim;
    bit  done;
    cmd_t cmd;
    pos_t pos;
    cmd = items.cmd;
    pos = items.position;
    case (cmd)
      CMD_FAT_WR: begin
        if (items.slot < FAT_ENTRIES) fat_links[items.slot] = items.next_cluster;
        push_answer(NO_CLUSTER, ST_OK, 1'b1);
      end
      CMD_DIR_WR: begin
        if (items.slot < DIR_ENTRIES) begin
          dir_names[items.slot]  = items.file_name;
          dir_starts[items.slot] = items.start_cluster;
        end
        push_answer(NO_CLUSTER, ST_OK, 1'b1);
      end
      default: begin
        hit = find_dir_slot(items.file_name);
        done = 1'b0;
        if (hit < 0) begin
          push_answer(NO_CLUSTER, ST_NOT_FOUND, 1'b1);
        end else if (cmd == CMD_LIST) begin
          lim = (FAT_ENTRIES < MAX_LIST) ? FAT_ENTRIES : MAX_LIST;
          c = int'(dir_starts[hit]);
          k = 0;
          while (!done) begin
            if (c >= FAT_ENTRIES) begin
              push_answer(cluster_t'(c), ST_BAD, 1'b1);
              done = 1'b1;
            end else if (fat_links[c] < 0) begin
              push_answer(cluster_t'(c), ST_OK, 1'b1);
              done = 1'b1;
            end else if (k == lim - 1) begin
              // chain still going at the cap: too long
              push_answer(cluster_t'(c), ST_BAD, 1'b1);
              done = 1'b1;
            end else begin
              push_answer(cluster_t'(c), ST_OK, 1'b0);
              k++;
              c = int'(fat_links[c]);
            end
          end
        end else if (pos == 0) begin
          push_answer(NO_CLUSTER, ST_BAD, 1'b1);
        end else begin
          c = int'(dir_starts[hit]);
          for (k = 1; k < int'(pos) && !done; k++) begin
            if (c >= FAT_ENTRIES || k >= FAT_ENTRIES) begin
              push_answer(NO_CLUSTER, ST_BAD, 1'b1);
              done = 1'b1;
            end else if (fat_links[c] < 0) begin
              push_answer(NO_CLUSTER, ST_PAST_END, 1'b1);
              done = 1'b1;
            end else begin
              c = int'(fat_links[c]);
            end
          end
          if (!done) begin
            if (c >= FAT_ENTRIES) push_answer(NO_CLUSTER, ST_BAD, 1'b1);
            else push_answer(cluster_t'(c), ST_OK, 1'b1);
          end
        end
      end
    endcase
  endtask

  task automatic check_result();
    answer_t want;
    if (answer_queue.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: cluster %0d status %0d last %0b",
                                results.cluster, results.status, results.last));
      return;
    end
    want = answer_queue.pop_front();
    if (results.cluster !== want.cluster) begin
      report_mismatch($sformatf("cluster %0d, expected %0d", results.cluster, want.cluster));
    end
    if (results.status !== want.status) begin
      report_mismatch($sformatf("status %0d, expected %0d", results.status, want.status));
    end
    if (results.last !== want.last) begin
      report_mismatch($sformatf("last %0b, expected %0b", results.last, want.last));
    end
  endtask

  // Output side first, so a result never meets an expectation made on the same edge
  always @(posedge clk) begin
    if (rst) begin
      answer_queue.delete();
      dir_span    = '0;
      outstanding = 0;
      mismatches  = 0;
    end else begin
      if (cfg_we) dir_span = cfg_wdata;
      if (results.valid && results.ready) check_result();
      if (items.valid && items.ready) predict_answers();
      outstanding = answer_queue.size();
    end
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fcw_pkg::*;

  localparam int FAT_N       = 64;
  localparam int DIR_N       = 16;
  localparam int ITEM_TARGET = 430;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 40;
  localparam int TAIL_CYCLES = 200;

  logic   clk = 1'b0;
  logic   rst;
  logic   cfg_we;
  count_t cfg_wdata;

  int unsigned outstanding;
  int unsigned mismatches;

  fcw_item_if   item_bus ();
  fcw_result_if result_bus ();

  fat_chain_walker_top #(
    .FAT_ENTRIES (FAT_N),
    .DIR_ENTRIES (DIR_N)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .items     (item_bus),
    .results   (result_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  fcw_result_checker #(
    .FAT_ENTRIES (FAT_N),
    .DIR_ENTRIES (DIR_N)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .items       (item_bus),
    .results     (result_bus),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus bookkeeping: names placed in the directory, chain heads of the layout
  name_t       known_names [DIR_N];
  int          chain_heads [$];
  int unsigned dir_span;
  int unsigned items_sent;
  int unsigned send_calm;
  int unsigned recv_calm;
  bit          hold_results;

  function automatic int unsigned pick_gap(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic name_t rand_name();
    return name_t'({$urandom, $urandom});
  endfunction

  task automatic send_cmd(input cmd_t cmd, input slot_t slot, input cluster_t nxt,
                          input name_t name, input start_t start, input pos_t pos);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_bus.valid         <= 1'b1;
    item_bus.cmd           <= cmd;
    item_bus.slot          <= slot;
    item_bus.next_cluster  <= nxt;
    item_bus.file_name     <= name;
    item_bus.start_cluster <= start;
    item_bus.position      <= pos;
    do @(posedge clk); while (!item_bus.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_fat(input int slot, input cluster_t nxt);
    send_cmd(CMD_FAT_WR, slot_t'(slot), nxt, rand_name(), start_t'($urandom),
             pos_t'($urandom_range(0, 64)));
  endtask

  task automatic write_dir(input int slot, input name_t name, input int start);
    if (slot < DIR_N) known_names[slot] = name;
    send_cmd(CMD_DIR_WR, slot_t'(slot), cluster_t'($urandom), name, start_t'(start),
             pos_t'($urandom_range(0, 64)));
  endtask

  task automatic lookup(input cmd_t cmd, input name_t name, input int pos);
    send_cmd(cmd, slot_t'($urandom), cluster_t'($urandom), name, start_t'($urandom),
             pos_t'(pos));
  endtask

  // Sender stops offering until every expected result has come back
  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_dir_count(input int value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= count_t'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    dir_span = (value > DIR_N) ? DIR_N : value;
  endtask

  // Shuffle the clusters into chains of mixed length; a few end in a loop
  task automatic lay_out_chains();
    int       perm [FAT_N];
    int       tmp;
    int       i;
    int       j;
    int       seg;
    int       r;
    cluster_t link;
    for (i = 0; i < FAT_N; i++) perm[i] = i;
    for (i = FAT_N - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    chain_heads.delete();
    i = 0;
    while (i < FAT_N) begin
      seg = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      if (i + seg > FAT_N) seg = FAT_N - i;
      chain_heads.push_back(perm[i]);
      for (j = 0; j < seg; j++) begin
        if (j < seg - 1) begin
          link = cluster_t'(perm[i + j + 1]);
        end else begin
          r = $urandom_range(0, 9);
          if (r < 7) link = NO_CLUSTER;
          else if (r < 9) link = cluster_t'(-$urandom_range(2, 64));
          else link = cluster_t'(perm[i + $urandom_range(0, seg - 1)]);
        end
        write_fat(perm[i + j], link);
      end
      i += seg;
    end
  endtask

  task automatic fill_directory();
    name_t name;
    int    start;
    for (int s = 0; s < DIR_N; s++) begin
      name = (s > 0 && $urandom_range(0, 9) == 0) ? known_names[$urandom_range(0, s - 1)]
                                                   : rand_name();
      start = ($urandom_range(0, 99) < 85) ? chain_heads[$urandom_range(0, chain_heads.size() - 1)]
                                           : $urandom_range(0, FAT_N - 1);
      write_dir(s, name, start);
    end
  endtask

  function automatic name_t pick_name();
    int r;
    r = $urandom_range(0, 99);
    if (dir_span != 0 && r < 80) return known_names[$urandom_range(0, dir_span - 1)];
    if (r < 90) return known_names[$urandom_range(0, DIR_N - 1)];
    return rand_name();
  endfunction

  function automatic int pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 13) return 64;
    if (r < 85) return $urandom_range(1, 10);
    return $urandom_range(11, 63);
  endfunction

  task automatic send_random_cmd();
    int       r;
    int       slot;
    cluster_t link;
    name_t    name;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      r = $urandom_range(0, 99);
      if (r < 40) link = NO_CLUSTER;
      else if (r < 50) link = cluster_t'(-$urandom_range(2, 64));
      else link = cluster_t'($urandom_range(0, FAT_N - 1));
      write_fat($urandom_range(0, FAT_N - 1), link);
    end else if (r < 20) begin
      slot = ($urandom_range(0, 99) < 80) ? $urandom_range(0, DIR_N - 1) : $urandom_range(16, 63);
      name = ($urandom_range(0, 4) == 0) ? known_names[$urandom_range(0, DIR_N - 1)]
                                         : rand_name();
      write_dir(slot, name, $urandom_range(0, FAT_N - 1));
    end else if (r < 60) begin
      lookup(CMD_LIST, pick_name(), $urandom_range(0, 64));
    end else begin
      lookup(CMD_FIND, pick_name(), pick_position());
    end
  endtask

  // Receiver: random stalls per transfer, plus one long hold-off on request
  initial begin
    int unsigned gap;
    result_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_results) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end
      gap = pick_gap(recv_calm);
      if (gap != 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      @(negedge clk);
    end
  end

  initial begin
    #30ms;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int          phase;
    int unsigned phase_left;
    name_t       dup_name;
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    item_bus.valid         = 1'b0;
    item_bus.cmd           = CMD_FAT_WR;
    item_bus.slot          = '0;
    item_bus.next_cluster  = '0;
    item_bus.file_name     = '0;
    item_bus.start_cluster = '0;
    item_bus.position      = '0;
    hold_results           = 1'b0;
    items_sent             = 0;
    send_calm              = 0;
    recv_calm              = 0;
    dir_span               = 0;
    for (int s = 0; s < DIR_N; s++) known_names[s] = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty directory: lookups miss without touching any table
    set_dir_count(0);
    lookup(CMD_LIST, rand_name(), 3);
    lookup(CMD_FIND, rand_name(), 1);

    // One chain through the whole table, 0 -> 63
    for (int i = 0; i < FAT_N - 1; i++) write_fat(i, cluster_t'(i + 1));
    write_fat(FAT_N - 1, NO_CLUSTER);
    for (int s = 0; s < DIR_N; s++) write_dir(s, rand_name(), $urandom_range(0, FAT_N - 1));
    set_dir_count(16);

    dup_name = rand_name();
    write_dir(0, '0, 0);
    write_dir(15, '1, 60);
    write_dir(1, dup_name, 62);
    write_dir(2, dup_name, 5);              // duplicate: slot 1 must win
    write_dir(63, rand_name(), 7);          // slot out of range, ignored
    lookup(CMD_LIST, '0, 0);                // full-length chain
    lookup(CMD_LIST, '1, 0);
    lookup(CMD_LIST, dup_name, 0);
    lookup(CMD_LIST, rand_name(), 0);       // miss
    lookup(CMD_FIND, '0, 0);                // position zero
    lookup(CMD_FIND, '0, 1);
    lookup(CMD_FIND, '0, 64);
    lookup(CMD_FIND, '1, 5);                // past end
    lookup(CMD_FIND, '1, 4);
    write_fat(63, cluster_t'(0));           // close the loop
    lookup(CMD_LIST, '0, 0);                // too long
    lookup(CMD_FIND, '0, 64);
    write_fat(63, cluster_t'(-64));         // end marker other than -1
    lookup(CMD_LIST, dup_name, 0);
    write_fat(0, cluster_t'(63));
    lookup(CMD_LIST, '0, 0);
    set_dir_count(1);
    lookup(CMD_LIST, dup_name, 0);          // present but beyond the count
    lookup(CMD_FIND, '0, 2);
    set_dir_count(0);
    lookup(CMD_FIND, '0, 1);

    lay_out_chains();
    fill_directory();

    phase = 0;
    phase_left = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase_left == 0) begin
        case (phase % 6)
          0, 2, 4: set_dir_count(16);
          1:       set_dir_count(1);
          3:       set_dir_count($urandom_range(2, 15));
          default: set_dir_count($urandom_range(0, 16));
        endcase
        // long stall on the result side while items keep coming
        if (phase == 2) hold_results = 1'b1;
        phase++;
        phase_left = PHASE_ITEMS;
      end
      send_random_cmd();
      phase_left--;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
